/* hw/rtl/gsdc_pkg.sv */
// ----------------------------------------------------------------------------
// gsdc_pkg
// Types, codes and the dim level table for the gesture switch/dimmer block.
// ----------------------------------------------------------------------------
package gsdc_pkg;

    localparam int FUNC_W    = 2;
    localparam int GEST_W    = 3;
    localparam int LEVEL_W   = 3;
    localparam int PWM_W     = 8;
    localparam int TIMER_W   = 16;
    localparam int HOLD_W    = 10;
    localparam int ACT_W     = HOLD_W + 1;
    localparam int STEP_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // transaction function codes
    localparam logic [FUNC_W-1:0] FUNC_EVENT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PROCESS = 2'd2;

    // gesture codes
    localparam logic [GEST_W-1:0] G_UP    = 3'd0;
    localparam logic [GEST_W-1:0] G_DOWN  = 3'd1;
    localparam logic [GEST_W-1:0] G_RIGHT = 3'd2;
    localparam logic [GEST_W-1:0] G_LEFT  = 3'd3;
    localparam logic [GEST_W-1:0] G_FWD   = 3'd4;
    localparam logic [GEST_W-1:0] G_BACK  = 3'd5;
    localparam logic [GEST_W-1:0] G_CW    = 3'd6;
    localparam logic [GEST_W-1:0] G_CCW   = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TUNE_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_HALF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_HOLD     = 3'd3;

    localparam logic [TIMER_W-1:0] INIT_DELAY_RST   = 16'd0;
    localparam logic [TIMER_W-1:0] TUNE_TIMEOUT_RST = 16'd3000;
    localparam logic [HOLD_W-1:0]  FLASH_HALF_RST   = 10'd100;
    localparam logic [HOLD_W-1:0]  ACT_HOLD_RST     = 10'd200;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd6;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [GEST_W-1:0] gesture;
    } item_t;

    typedef struct packed {
        logic [3:0]         relays;
        logic [3:0]         gesture_bits;
        logic [PWM_W-1:0]   pwm_compare;
        logic               status_led_level;
        logic               tune_mode;
        logic [LEVEL_W-1:0] dim_level;
    } result_t;

    function automatic logic [PWM_W-1:0] level_to_pwm(input logic [LEVEL_W-1:0] lvl);
        logic [PWM_W-1:0] v;
        case (lvl)
            3'd0:    v = 8'd0;
            3'd1:    v = 8'd40;
            3'd2:    v = 8'd50;
            3'd3:    v = 8'd70;
            3'd4:    v = 8'd100;
            3'd5:    v = 8'd150;
            default: v = 8'd200;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/gsdc_in_reg.sv */
// ----------------------------------------------------------------------------
// gsdc_in_reg
// Input register stage: holds one transaction until the core takes it.
// ----------------------------------------------------------------------------
module gsdc_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  gsdc_pkg::item_t in_item,
    output logic           hold_valid,
    input  logic           advance,
    output gsdc_pkg::item_t hold_item
);

    logic            valid_reg;
    gsdc_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

/* hw/rtl/gsdc_core.sv */
// ----------------------------------------------------------------------------
// gsdc_core
// Controller state, configuration registers and the per-transaction update.
// The result reflects the state after the transaction.
// ----------------------------------------------------------------------------
module gsdc_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [gsdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gsdc_pkg::CFG_DAT_W-1:0]      cfg_wdata,
    input  logic                                fire,
    input  gsdc_pkg::item_t                     item,
    output gsdc_pkg::result_t                   result
);

    localparam logic [gsdc_pkg::STEP_W-1:0] ST_INIT   = 3'd0;
    localparam logic [gsdc_pkg::STEP_W-1:0] ST_NORMAL = 3'd1;
    localparam logic [gsdc_pkg::STEP_W-1:0] ST_ENTER  = 3'd2;
    localparam logic [gsdc_pkg::STEP_W-1:0] ST_SHOW   = 3'd3;
    localparam logic [gsdc_pkg::STEP_W-1:0] ST_ARM    = 3'd4;
    localparam logic [gsdc_pkg::STEP_W-1:0] ST_TUNE   = 3'd5;
    localparam logic [gsdc_pkg::STEP_W-1:0] ST_CLEAN  = 3'd6;

    logic [gsdc_pkg::TIMER_W-1:0] tune_timeout_reg;
    logic [gsdc_pkg::HOLD_W-1:0]  flash_half_reg, act_hold_reg;

    logic [gsdc_pkg::STEP_W-1:0]   mode_reg, mode_next;
    logic [7:0]                    pend_reg, pend_next;
    logic [3:0]                    relay_reg, relay_next;
    logic [3:0]                    outb_reg, outb_next;
    logic [gsdc_pkg::PWM_W-1:0]    pwm_reg, pwm_next;
    logic [gsdc_pkg::LEVEL_W-1:0]  level_reg, level_next;
    logic signed [gsdc_pkg::ACT_W-1:0] act_reg, act_next;
    logic [gsdc_pkg::TIMER_W-1:0]  tmo_reg, tmo_next;
    logic [gsdc_pkg::HOLD_W-1:0]   flc_reg, flc_next;
    logic                          flp_reg, flp_next;
    logic [gsdc_pkg::TIMER_W-1:0]  stc_reg, stc_next;
    logic                          led_reg, led_next;

    always_comb begin
        logic       do_toggle;
        logic [1:0] rb;
        logic [1:0] ob;
        logic       is_up;
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        relay_next = relay_reg;
        outb_next  = outb_reg;
        pwm_next   = pwm_reg;
        level_next = level_reg;
        act_next   = act_reg;
        tmo_next   = tmo_reg;
        flc_next   = flc_reg;
        flp_next   = flp_reg;
        stc_next   = stc_reg;
        led_next   = led_reg;
        do_toggle  = 1'b0;
        rb         = 2'd0;
        ob         = 2'd0;
        is_up      = 1'b0;
        if (fire) begin
            case (item.func)
                gsdc_pkg::FUNC_EVENT: begin
                    pend_next = pend_reg | (8'd1 << item.gesture);
                end
                gsdc_pkg::FUNC_TICK: begin
                    if (act_reg > 0) act_next = act_reg - 11'sd1;
                    if (tmo_reg != '0) tmo_next = tmo_reg - 16'd1;
                    if (flc_reg != '0) flc_next = flc_reg - 10'd1;
                    if (stc_reg != '0) stc_next = stc_reg - 16'd1;
                end
                gsdc_pkg::FUNC_PROCESS: begin
                    // status LED: flash while tuning, else end of activity hold
                    if (tmo_reg != '0) begin
                        if (flc_reg == '0) begin
                            flc_next = flash_half_reg;
                            flp_next = !flp_reg;
                            led_next = flp_reg;
                        end
                    end else if (act_reg == 0) begin
                        act_next = -11'sd1;
                        led_next = 1'b1;
                    end

                    case (mode_reg)
                        ST_INIT: begin
                            if (stc_reg == '0) begin
                                relay_next = '0;
                                outb_next  = '0;
                                pwm_next   = '0;
                                level_next = gsdc_pkg::LEVEL_MAX;
                                mode_next  = ST_NORMAL;
                            end
                        end
                        ST_NORMAL: begin
                            if (pend_reg[gsdc_pkg::G_UP]) begin
                                pend_next[gsdc_pkg::G_UP] = 1'b0;
                                do_toggle = 1'b1; rb = 2'd3; ob = 2'd0; is_up = 1'b1;
                            end else if (pend_reg[gsdc_pkg::G_DOWN]) begin
                                pend_next[gsdc_pkg::G_DOWN] = 1'b0;
                                do_toggle = 1'b1; rb = 2'd1; ob = 2'd2;
                            end else if (pend_reg[gsdc_pkg::G_RIGHT]) begin
                                pend_next[gsdc_pkg::G_RIGHT] = 1'b0;
                                do_toggle = 1'b1; rb = 2'd2; ob = 2'd1;
                            end else if (pend_reg[gsdc_pkg::G_LEFT]) begin
                                pend_next[gsdc_pkg::G_LEFT] = 1'b0;
                                do_toggle = 1'b1; rb = 2'd0; ob = 2'd3;
                            end else if (pend_reg[gsdc_pkg::G_FWD]) begin
                                pend_next[gsdc_pkg::G_FWD] = 1'b0;
                                mode_next = ST_ENTER;
                            end else if (pend_reg[gsdc_pkg::G_BACK]) begin
                                pend_next[gsdc_pkg::G_BACK] = 1'b0;
                            end else if (pend_reg[gsdc_pkg::G_CW]) begin
                                pend_next[gsdc_pkg::G_CW] = 1'b0;
                                relay_next = 4'hF;
                                outb_next  = 4'hF;
                                pwm_next   = gsdc_pkg::level_to_pwm(level_reg);
                            end else if (pend_reg[gsdc_pkg::G_CCW]) begin
                                pend_next[gsdc_pkg::G_CCW] = 1'b0;
                                relay_next = '0;
                                outb_next  = '0;
                                pwm_next   = '0;
                            end
                        end
                        ST_ENTER: begin
                            relay_next = '0;
                            outb_next  = '0;
                            pwm_next   = '0;
                            tmo_next   = tune_timeout_reg;
                            mode_next  = ST_SHOW;
                        end
                        ST_SHOW: begin
                            pwm_next  = gsdc_pkg::level_to_pwm(level_reg);
                            mode_next = ST_ARM;
                        end
                        ST_ARM: begin
                            tmo_next  = tune_timeout_reg;
                            mode_next = ST_TUNE;
                        end
                        ST_TUNE: begin
                            if (tmo_reg == '0) begin
                                mode_next = ST_CLEAN;
                            end else if (pend_reg[gsdc_pkg::G_CW]) begin
                                pend_next[gsdc_pkg::G_CW] = 1'b0;
                                tmo_next = tune_timeout_reg;
                                if (level_reg < gsdc_pkg::LEVEL_MAX)
                                    level_next = level_reg + 3'd1;
                                pwm_next = gsdc_pkg::level_to_pwm(level_next);
                            end else if (pend_reg[gsdc_pkg::G_CCW]) begin
                                pend_next[gsdc_pkg::G_CCW] = 1'b0;
                                tmo_next = tune_timeout_reg;
                                if (level_reg != '0) level_next = level_reg - 3'd1;
                                pwm_next = gsdc_pkg::level_to_pwm(level_next);
                            end
                        end
                        ST_CLEAN: begin
                            pend_next  = '0;
                            mode_next  = ST_NORMAL;
                            relay_next = '0;
                            outb_next  = '0;
                            pwm_next   = '0;
                            led_next   = 1'b1;
                        end
                        default: begin
                            mode_next = ST_NORMAL;
                        end
                    endcase

                    if (do_toggle) begin
                        if (!relay_reg[rb]) begin
                            relay_next[rb] = 1'b1;
                            outb_next[ob]  = 1'b1;
                            if (is_up) pwm_next = gsdc_pkg::level_to_pwm(gsdc_pkg::LEVEL_MAX);
                        end else begin
                            relay_next[rb] = 1'b0;
                            outb_next[ob]  = 1'b0;
                            if (is_up) pwm_next = '0;
                        end
                        act_next = $signed({1'b0, act_hold_reg});
                        led_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // an init_delay write only reloads the startup counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tune_timeout_reg <= gsdc_pkg::TUNE_TIMEOUT_RST;
            flash_half_reg   <= gsdc_pkg::FLASH_HALF_RST;
            act_hold_reg     <= gsdc_pkg::ACT_HOLD_RST;
            mode_reg         <= ST_INIT;
            pend_reg         <= '0;
            relay_reg        <= '0;
            outb_reg         <= '0;
            pwm_reg          <= '0;
            level_reg        <= '0;
            act_reg          <= '0;
            tmo_reg          <= '0;
            flc_reg          <= '0;
            flp_reg          <= 1'b0;
            stc_reg          <= gsdc_pkg::INIT_DELAY_RST;
            led_reg          <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            relay_reg <= relay_next;
            outb_reg  <= outb_next;
            pwm_reg   <= pwm_next;
            level_reg <= level_next;
            act_reg   <= act_next;
            tmo_reg   <= tmo_next;
            flc_reg   <= flc_next;
            flp_reg   <= flp_next;
            led_reg   <= led_next;
            stc_reg   <= stc_next;
            if (cfg_we) begin
                case (cfg_index)
                    gsdc_pkg::CFG_INIT_DELAY: begin
                        stc_reg <= cfg_wdata;
                    end
                    gsdc_pkg::CFG_TUNE_TIMEOUT: tune_timeout_reg <= cfg_wdata;
                    gsdc_pkg::CFG_FLASH_HALF:   flash_half_reg <= cfg_wdata[gsdc_pkg::HOLD_W-1:0];
                    gsdc_pkg::CFG_ACT_HOLD:     act_hold_reg <= cfg_wdata[gsdc_pkg::HOLD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        result.relays           = relay_next;
        result.gesture_bits     = outb_next;
        result.pwm_compare      = pwm_next;
        result.status_led_level = led_next;
        result.tune_mode        = (mode_next >= ST_ENTER) && (mode_next <= ST_TUNE);
        result.dim_level        = level_next;
    end

endmodule

/* hw/rtl/gsdc_out_reg.sv */
// ----------------------------------------------------------------------------
// gsdc_out_reg
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module gsdc_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  gsdc_pkg::result_t load_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              can_load,
    output gsdc_pkg::result_t out_data
);

    logic              valid_reg;
    gsdc_pkg::result_t data_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && can_load) begin
            data_reg <= load_data;
        end
    end

endmodule

/* hw/rtl/gesture_switch_dimmer_controller_top.sv */
// ----------------------------------------------------------------------------
// gesture_switch_dimmer_controller_top
// Gesture switch and dimmer controller: latches gesture events, counts timer
// ticks and runs the mode machine on process steps.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_func, s_gesture
//   m_       out  m_valid/m_ready    m_relays, m_gesture_bits, m_pwm_compare,
//                                    m_status_led_level, m_tune_mode, m_dim_level
//   cfg_     in   cfg_we             cfg_index, cfg_wdata
//
// One transaction per cycle sustained while m_ready stays high; on its way
// to m_valid a transaction passes the input register, then the state update
// into the result register. Every transaction yields exactly one result.
// Synchronous active-low reset; no clearing pass.
// A stalled result holds the result register; s_ready then stays high only
// while the input register is empty.
// ----------------------------------------------------------------------------
module gesture_switch_dimmer_controller_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [gsdc_pkg::FUNC_W-1:0]        s_func,
    input  logic [gsdc_pkg::GEST_W-1:0]        s_gesture,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [3:0]                         m_relays,
    output logic [3:0]                         m_gesture_bits,
    output logic [gsdc_pkg::PWM_W-1:0]         m_pwm_compare,
    output logic                               m_status_led_level,
    output logic                               m_tune_mode,
    output logic [gsdc_pkg::LEVEL_W-1:0]       m_dim_level,
    input  logic                               cfg_we,
    input  logic [gsdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gsdc_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

    gsdc_pkg::item_t   in_item, hold_item;
    gsdc_pkg::result_t core_result, out_data;
    logic              hold_valid, can_load, fire;

    assign in_item.func    = s_func;
    assign in_item.gesture = s_gesture;
    assign fire            = hold_valid && can_load;

    gsdc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (in_item),
        .hold_valid (hold_valid),
        .advance    (can_load),
        .hold_item  (hold_item)
    );

    gsdc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (hold_item),
        .result    (core_result)
    );

    gsdc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (hold_valid),
        .load_data (core_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .can_load  (can_load),
        .out_data  (out_data)
    );

    assign m_relays           = out_data.relays;
    assign m_gesture_bits     = out_data.gesture_bits;
    assign m_pwm_compare      = out_data.pwm_compare;
    assign m_status_led_level = out_data.status_led_level;
    assign m_tune_mode        = out_data.tune_mode;
    assign m_dim_level        = out_data.dim_level;

endmodule

/* hw/rtl/gsdc_checker.sv */
// ----------------------------------------------------------------------------
// gsdc_checker
// Port-level checks for the gesture switch/dimmer controller.
// ----------------------------------------------------------------------------
module gsdc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_relays,
    input logic [3:0] m_gesture_bits,
    input logic [7:0] m_pwm_compare,
    input logic       m_tune_mode,
    input logic [2:0] m_dim_level
);

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_relays) && $stable(m_pwm_compare))
        else $error("result changed while stalled");

    // each relay and its gesture output bit always move together
    a_bits_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_gesture_bits == {m_relays[0], m_relays[1], m_relays[2], m_relays[3]}))
        else $error("gesture bits out of step with relays");

    // no result is offered after a reset edge
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // level saturates and PWM comes from the level table
    a_level_pwm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_dim_level <= 3'd6 &&
            (m_pwm_compare == 8'd0 || m_pwm_compare == 8'd40 || m_pwm_compare == 8'd50 ||
             m_pwm_compare == 8'd70 || m_pwm_compare == 8'd100 ||
             m_pwm_compare == 8'd150 || m_pwm_compare == 8'd200))
        else $error("dim level or PWM value out of range");

endmodule

bind gesture_switch_dimmer_controller_top gsdc_checker u_gsdc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_relays       (m_relays),
    .m_gesture_bits (m_gesture_bits),
    .m_pwm_compare  (m_pwm_compare),
    .m_tune_mode    (m_tune_mode),
    .m_dim_level    (m_dim_level)
);

/* tb/gesture_switch_dimmer_controller_top_test.sv */
// ----------------------------------------------------------------------------
// gesture_switch_dimmer_controller_top_test
// Drives event, tick and process transactions into the gesture switch/dimmer
// controller and checks every output snapshot against a cycle-free model of
// the mode machine, relays, dim level and status LED. Directed startup,
// toggle and tune sequences come first, then random traffic under several
// register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module gesture_switch_dimmer_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;

    localparam logic [gsdc_pkg::FUNC_W-1:0]    FUNC_UNUSED     = 2'd3;
    localparam logic [gsdc_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd4;

    // relay and output pin positions per channel
    localparam int RLY_LEFT  = 0;
    localparam int RLY_DOWN  = 1;
    localparam int RLY_RIGHT = 2;
    localparam int RLY_UP    = 3;
    localparam int PIN_UP    = 0;
    localparam int PIN_RIGHT = 1;
    localparam int PIN_DOWN  = 2;
    localparam int PIN_LEFT  = 3;

    localparam logic [0:7][gsdc_pkg::PWM_W-1:0] DIM_PWM =
        {8'd0, 8'd40, 8'd50, 8'd70, 8'd100, 8'd150, 8'd200, 8'd200};

    typedef enum logic [2:0] {
        MODE_INIT, MODE_NORMAL, MODE_ENTER, MODE_SHOW, MODE_ARM, MODE_TUNE, MODE_CLEAN
    } dim_mode_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [gsdc_pkg::FUNC_W-1:0]    s_func;
    logic [gsdc_pkg::GEST_W-1:0]    s_gesture;
    logic                           m_valid;
    logic                           m_ready;
    logic [3:0]                     m_relays;
    logic [3:0]                     m_gesture_bits;
    logic [gsdc_pkg::PWM_W-1:0]     m_pwm_compare;
    logic                           m_status_led_level;
    logic                           m_tune_mode;
    logic [gsdc_pkg::LEVEL_W-1:0]   m_dim_level;
    logic                           cfg_we;
    logic [gsdc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gsdc_pkg::CFG_DAT_W-1:0] cfg_wdata;

    gesture_switch_dimmer_controller_top dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_gesture          (s_gesture),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_relays           (m_relays),
        .m_gesture_bits     (m_gesture_bits),
        .m_pwm_compare      (m_pwm_compare),
        .m_status_led_level (m_status_led_level),
        .m_tune_mode        (m_tune_mode),
        .m_dim_level        (m_dim_level),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata)
    );

    // model state
    dim_mode_t                    cur_mode;
    logic [7:0]                   pending;
    logic [3:0]                   relay_st;
    logic [3:0]                   pin_st;
    logic [gsdc_pkg::PWM_W-1:0]   pwm_st;
    logic [gsdc_pkg::LEVEL_W-1:0] level_st;
    logic                         flash_ph;
    logic                         led_st;
    int                           act_count;
    int                           tmo_count;
    int                           flash_cnt;
    int                           boot_count;

    // model copy of the registers
    int tune_timeout_r;
    int flash_half_r;
    int act_hold_r;

    gsdc_pkg::result_t panel_state_q[$];
    int                mismatches;
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                rx_hold_left;
    int                idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic void all_off();
        relay_st = '0;
        pin_st   = '0;
        pwm_st   = '0;
    endfunction

    function automatic bit take_pending(logic [gsdc_pkg::GEST_W-1:0] g);
        if (pending[g]) begin
            pending[g] = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void toggle_channel(int rly, int pin, bit is_up);
        if (!relay_st[rly]) begin
            relay_st[rly] = 1'b1;
            pin_st[pin]   = 1'b1;
            if (is_up) pwm_st = DIM_PWM[gsdc_pkg::LEVEL_MAX];
        end else begin
            relay_st[rly] = 1'b0;
            pin_st[pin]   = 1'b0;
            if (is_up) pwm_st = '0;
        end
        act_count = act_hold_r;
        led_st    = 1'b0;
    endfunction

    function automatic gsdc_pkg::result_t panel_advance(logic [gsdc_pkg::FUNC_W-1:0] f,
                                                        logic [gsdc_pkg::GEST_W-1:0] g);
        gsdc_pkg::result_t r;
        case (f)
            gsdc_pkg::FUNC_EVENT: pending[g] = 1'b1;
            gsdc_pkg::FUNC_TICK: begin
                if (act_count > 0) act_count--;
                if (tmo_count > 0) tmo_count--;
                if (flash_cnt > 0) flash_cnt--;
                if (boot_count > 0) boot_count--;
            end
            gsdc_pkg::FUNC_PROCESS: begin
                // LED first: flash while the tune timeout runs, else activity hold
                if (tmo_count > 0) begin
                    if (flash_cnt == 0) begin
                        flash_cnt = flash_half_r;
                        flash_ph  = ~flash_ph;
                        led_st    = ~flash_ph;
                    end
                end else if (act_count == 0) begin
                    act_count = -1;
                    led_st    = 1'b1;
                end
                case (cur_mode)
                    MODE_INIT: begin
                        if (boot_count == 0) begin
                            all_off();
                            level_st = gsdc_pkg::LEVEL_MAX;
                            cur_mode = MODE_NORMAL;
                        end
                    end
                    MODE_NORMAL: begin
                        if (take_pending(gsdc_pkg::G_UP))
                            toggle_channel(RLY_UP, PIN_UP, 1'b1);
                        else if (take_pending(gsdc_pkg::G_DOWN))
                            toggle_channel(RLY_DOWN, PIN_DOWN, 1'b0);
                        else if (take_pending(gsdc_pkg::G_RIGHT))
                            toggle_channel(RLY_RIGHT, PIN_RIGHT, 1'b0);
                        else if (take_pending(gsdc_pkg::G_LEFT))
                            toggle_channel(RLY_LEFT, PIN_LEFT, 1'b0);
                        else if (take_pending(gsdc_pkg::G_FWD)) cur_mode = MODE_ENTER;
                        else if (take_pending(gsdc_pkg::G_BACK)) begin
                        end else if (take_pending(gsdc_pkg::G_CW)) begin
                            relay_st = '1;
                            pin_st   = '1;
                            pwm_st   = DIM_PWM[level_st];
                        end else if (take_pending(gsdc_pkg::G_CCW)) all_off();
                    end
                    MODE_ENTER: begin
                        all_off();
                        tmo_count = tune_timeout_r;
                        cur_mode  = MODE_SHOW;
                    end
                    MODE_SHOW: begin
                        pwm_st   = DIM_PWM[level_st];
                        cur_mode = MODE_ARM;
                    end
                    MODE_ARM: begin
                        tmo_count = tune_timeout_r;
                        cur_mode  = MODE_TUNE;
                    end
                    MODE_TUNE: begin
                        if (tmo_count == 0) begin
                            cur_mode = MODE_CLEAN;
                        end else if (take_pending(gsdc_pkg::G_CW)) begin
                            tmo_count = tune_timeout_r;
                            if (level_st < gsdc_pkg::LEVEL_MAX) level_st = level_st + 1'b1;
                            pwm_st = DIM_PWM[level_st];
                        end else if (take_pending(gsdc_pkg::G_CCW)) begin
                            tmo_count = tune_timeout_r;
                            if (level_st > 0) level_st = level_st - 1'b1;
                            pwm_st = DIM_PWM[level_st];
                        end
                    end
                    MODE_CLEAN: begin
                        pending  = '0;
                        cur_mode = MODE_NORMAL;
                        all_off();
                        led_st   = 1'b1;
                    end
                    default: cur_mode = MODE_NORMAL;
                endcase
            end
            default: ;
        endcase
        r.relays           = relay_st;
        r.gesture_bits     = pin_st;
        r.pwm_compare      = pwm_st;
        r.status_led_level = led_st;
        r.tune_mode        = (cur_mode >= MODE_ENTER) && (cur_mode <= MODE_TUNE);
        r.dim_level        = level_st;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic send_item(logic [gsdc_pkg::FUNC_W-1:0] f, logic [gsdc_pkg::GEST_W-1:0] g);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= f;
        s_gesture <= g;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        panel_state_q.push_back(panel_advance(f, g));
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (panel_state_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [gsdc_pkg::CFG_IDX_W-1:0] idx,
                             logic [gsdc_pkg::CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            gsdc_pkg::CFG_INIT_DELAY:   boot_count     = val;
            gsdc_pkg::CFG_TUNE_TIMEOUT: tune_timeout_r = val;
            gsdc_pkg::CFG_FLASH_HALF:   flash_half_r   = val[gsdc_pkg::HOLD_W-1:0];
            gsdc_pkg::CFG_ACT_HOLD:     act_hold_r     = val[gsdc_pkg::HOLD_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly gesture-then-process bursts with ticks in between, some noise
    task automatic traffic_mix(int n_items);
        int sent;
        int k;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 70) begin
                send_item(gsdc_pkg::FUNC_EVENT, 3'($urandom_range(7)));
                sent++;
                repeat ($urandom_range(1, 3)) begin
                    repeat ($urandom_range(0, 2)) begin
                        send_item(gsdc_pkg::FUNC_TICK, 3'($urandom_range(7)));
                        sent++;
                    end
                    send_item(gsdc_pkg::FUNC_PROCESS, 3'($urandom_range(7)));
                    sent++;
                end
            end else begin
                k = int'($urandom_range(3));
                send_item(k[gsdc_pkg::FUNC_W-1:0], 3'($urandom_range(7)));
                if (k[gsdc_pkg::FUNC_W-1:0] != FUNC_UNUSED) sent++;
            end
        end
    endtask

    task automatic test_startup_wait();
        write_reg(gsdc_pkg::CFG_INIT_DELAY, 16'd2);
        send_item(FUNC_UNUSED, gsdc_pkg::G_CCW);
        send_item(gsdc_pkg::FUNC_PROCESS, gsdc_pkg::G_UP);
        send_item(gsdc_pkg::FUNC_TICK, gsdc_pkg::G_UP);
        send_item(gsdc_pkg::FUNC_PROCESS, gsdc_pkg::G_UP);
        send_item(gsdc_pkg::FUNC_TICK, gsdc_pkg::G_UP);
        send_item(gsdc_pkg::FUNC_PROCESS, gsdc_pkg::G_UP);
    endtask

    task automatic test_channel_toggles();
        send_item(gsdc_pkg::FUNC_EVENT, gsdc_pkg::G_LEFT);
        send_item(gsdc_pkg::FUNC_EVENT, gsdc_pkg::G_RIGHT);
        send_item(gsdc_pkg::FUNC_EVENT, gsdc_pkg::G_DOWN);
        send_item(gsdc_pkg::FUNC_EVENT, gsdc_pkg::G_UP);
        repeat (4) send_item(gsdc_pkg::FUNC_PROCESS, gsdc_pkg::G_UP);
        // left switching off must clear its pin
        send_item(gsdc_pkg::FUNC_EVENT, gsdc_pkg::G_LEFT);
        send_item(gsdc_pkg::FUNC_PROCESS, gsdc_pkg::G_UP);
        send_item(gsdc_pkg::FUNC_EVENT, gsdc_pkg::G_CCW);
        send_item(gsdc_pkg::FUNC_EVENT, gsdc_pkg::G_CW);
        send_item(gsdc_pkg::FUNC_EVENT, gsdc_pkg::G_BACK);
        repeat (3) send_item(gsdc_pkg::FUNC_PROCESS, gsdc_pkg::G_UP);
    endtask

    task automatic test_tune_timeout_zero();
        wait_all_results();
        write_reg(gsdc_pkg::CFG_TUNE_TIMEOUT, 16'd0);
        write_reg(gsdc_pkg::CFG_FLASH_HALF, 16'd0);
        write_reg(gsdc_pkg::CFG_ACT_HOLD, 16'd0);
        send_item(gsdc_pkg::FUNC_EVENT, gsdc_pkg::G_FWD);
        send_item(gsdc_pkg::FUNC_EVENT, gsdc_pkg::G_CW);
        repeat (5) send_item(gsdc_pkg::FUNC_PROCESS, gsdc_pkg::G_FWD);
    endtask

    task automatic test_unused_reg_index();
        wait_all_results();
        for (int i = CFG_SPARE_FIRST; i < 2 ** gsdc_pkg::CFG_IDX_W; i++)
            write_reg(i[gsdc_pkg::CFG_IDX_W-1:0], 16'($urandom));
        traffic_mix(12);
    endtask

    task automatic test_random_traffic(int tx_pct, int rx_pct, logic [15:0] init_d,
                                       logic [15:0] tmo, logic [15:0] flash,
                                       logic [15:0] hold, int n_items, int stall);
        wait_all_results();
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        write_reg(gsdc_pkg::CFG_INIT_DELAY, init_d);
        write_reg(gsdc_pkg::CFG_TUNE_TIMEOUT, tmo);
        write_reg(gsdc_pkg::CFG_FLASH_HALF, flash);
        write_reg(gsdc_pkg::CFG_ACT_HOLD, hold);
        if (stall > 0) rx_hold_left <= stall;
        traffic_mix(n_items);
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_result();
        gsdc_pkg::result_t want;
        if (panel_state_q.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
        end else begin
            want = panel_state_q.pop_front();
            if (m_relays !== want.relays)
                report_mismatch($sformatf("relays %h exp %h", m_relays, want.relays));
            if (m_gesture_bits !== want.gesture_bits)
                report_mismatch($sformatf("gesture_bits %h exp %h",
                                          m_gesture_bits, want.gesture_bits));
            if (m_pwm_compare !== want.pwm_compare)
                report_mismatch($sformatf("pwm_compare %0d exp %0d",
                                          m_pwm_compare, want.pwm_compare));
            if (m_status_led_level !== want.status_led_level)
                report_mismatch($sformatf("status_led_level %b exp %b",
                                          m_status_led_level, want.status_led_level));
            if (m_tune_mode !== want.tune_mode)
                report_mismatch($sformatf("tune_mode %b exp %b", m_tune_mode, want.tune_mode));
            if (m_dim_level !== want.dim_level)
                report_mismatch($sformatf("dim_level %0d exp %0d", m_dim_level, want.dim_level));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_result();
            m_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // long output stall, counted down here
    always @(posedge aclk) begin
        if (rx_hold_left > 0) rx_hold_left <= rx_hold_left - 1;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] no transaction for %0d cycles", $realtime, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_func       = '0;
        s_gesture    = '0;
        m_ready      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        mismatches   = 0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_left = 0;
        idle_cycles  = 0;

        cur_mode       = MODE_INIT;
        pending        = '0;
        relay_st       = '0;
        pin_st         = '0;
        pwm_st         = '0;
        level_st       = '0;
        flash_ph       = 1'b0;
        led_st         = 1'b0;
        act_count      = 0;
        tmo_count      = 0;
        flash_cnt      = 0;
        tune_timeout_r = gsdc_pkg::TUNE_TIMEOUT_RST;
        flash_half_r   = gsdc_pkg::FLASH_HALF_RST;
        act_hold_r     = gsdc_pkg::ACT_HOLD_RST;
        boot_count     = gsdc_pkg::INIT_DELAY_RST;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_startup_wait();
        test_channel_toggles();
        test_tune_timeout_zero();

        test_random_traffic(24, 74, 16'd3, 16'd1, 16'd1, 16'd1, 290, 0);
        test_random_traffic(24, 74, 16'd0, 16'd8, 16'd0, 16'd0, 290, 0);
        test_random_traffic(74, 24, 16'($urandom_range(20)), 16'($urandom_range(2, 40)),
                            16'($urandom_range(1, 8)), 16'($urandom_range(1, 16)), 290, 0);
        test_random_traffic(74, 24, 16'hFFFF, 16'd25, 16'hFFFF, 16'hFFFF, 290, 0);
        test_unused_reg_index();
        test_random_traffic(0, 0, 16'($urandom_range(10)), 16'($urandom_range(4, 60)),
                            16'($urandom_range(1, 20)), 16'($urandom_range(1, 40)), 290, 0);
        // saturated timeout; output held off at the start so the input backs up
        test_random_traffic(0, 0, 16'd0, 16'hFFFF, 16'($urandom_range(1, 1023)),
                            16'($urandom_range(1, 1023)), 290, 150);

        wait_all_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* gesture_switch_dimmer_controller_top.f */
hw/rtl/gsdc_pkg.sv
hw/rtl/gsdc_in_reg.sv
hw/rtl/gsdc_core.sv
hw/rtl/gsdc_out_reg.sv
hw/rtl/gesture_switch_dimmer_controller_top.sv
hw/rtl/gsdc_checker.sv
tb/gesture_switch_dimmer_controller_top_test.sv
